// ===== sv/tcfq_pkg.sv =====
// package for the two-class oldest-first fifo
// holds operation and status codes, control structs and default sizes
// no dependencies
`timescale 1ns / 1ps

package tcfq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 16;
  localparam int DEF_STAMP_BITS  = 16;
  localparam int PORT_TAG_W      = 16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQ_ANY = 2'd1,
    ACT_DEQ_DOG = 2'd2,
    ACT_DEQ_CAT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

endpackage

// ===== sv/tcfq_ifs.sv =====
// request and response channel interfaces for the two-class fifo
// depends on nothing; payload widths follow the port definitions
`timescale 1ns / 1ps

interface tcfq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        is_dog;
  logic [15:0] item_tag;

  modport source (output valid, action, is_dog, item_tag, input ready);
  modport sink (input valid, action, is_dog, item_tag, output ready);
endinterface

interface tcfq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_tag;
  logic        out_is_dog;

  modport source (output valid, status, out_tag, out_is_dog, input ready);
  modport sink (input valid, status, out_tag, out_is_dog, output ready);
endinterface

// ===== sv/tcfq_cell.sv =====
// one storage cell of a class queue chain: tag and arrival stamp
// loads the incoming entry at the tail position or takes its neighbor on pop
// depends on tcfq_pkg
`timescale 1ns / 1ps

module tcfq_cell
  import tcfq_pkg::*;
#(
  parameter int TAG_BITS   = DEF_TAG_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS,
  parameter int FILL_W     = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  q_ctl_t                ctl,
  input  logic [FILL_W-1:0]     fill,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic [STAMP_BITS-1:0] in_stamp,
  input  logic [TAG_BITS-1:0]   nbr_tag,
  input  logic [STAMP_BITS-1:0] nbr_stamp,
  output logic [TAG_BITS-1:0]   tag,
  output logic [STAMP_BITS-1:0] stamp
);

  logic load;

  assign load = ctl.push && (fill == FILL_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      tag   <= nbr_tag;
      stamp <= nbr_stamp;
    end else if (load) begin
      tag   <= in_tag;
      stamp <= in_stamp;
    end
  end

endmodule

// ===== sv/tcfq_chain.sv =====
// one class queue as a chain of cells with the head always in cell zero
// keeps the fill count and reports full and empty
// depends on tcfq_pkg and tcfq_cell
`timescale 1ns / 1ps

module tcfq_chain
  import tcfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  q_ctl_t                ctl,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic [STAMP_BITS-1:0] in_stamp,
  output logic [TAG_BITS-1:0]   head_tag,
  output logic [STAMP_BITS-1:0] head_stamp,
  output q_sts_t                sts
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic [TAG_BITS-1:0]   tags   [QUEUE_DEPTH+1];
  logic [STAMP_BITS-1:0] stamps [QUEUE_DEPTH+1];

  // past the last cell nothing moves in
  assign tags[QUEUE_DEPTH]   = '0;
  assign stamps[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tcfq_cell #(
      .TAG_BITS   (TAG_BITS),
      .STAMP_BITS (STAMP_BITS),
      .FILL_W     (FILL_W),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill),
      .in_tag    (in_tag),
      .in_stamp  (in_stamp),
      .nbr_tag   (tags[i+1]),
      .nbr_stamp (stamps[i+1]),
      .tag       (tags[i]),
      .stamp     (stamps[i])
    );
  end

  always_comb begin
    fill_next = fill;
    if (ctl.push) begin
      fill_next = fill + FILL_W'(1);
    end else if (ctl.pop) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  assign head_tag   = tags[0];
  assign head_stamp = stamps[0];
  assign sts.full   = (fill == FILL_W'(QUEUE_DEPTH));
  assign sts.empty  = (fill == '0);

endmodule

// ===== sv/two_class_fifo_oldest_first.sv =====
// top level of the two-class oldest-first fifo (dog and cat queues)
// depends on tcfq_pkg, tcfq_ifs, tcfq_chain and tcfq_cell
//
// usage:
//   req channel carries one operation per transaction: action (enqueue,
//   dequeue oldest of either class, dequeue dog, dequeue cat), is_dog and
//   item_tag. every transaction yields exactly one rsp transaction with
//   status, out_tag and out_is_dog.
//   enqueue stamps the entry with a global arrival count; dequeue-any takes
//   the head with the older stamp, compared modulo 2^STAMP_BITS.
//   a full queue drops the entry with status full; an empty request gives
//   status empty and leaves the state alone.
// timing:
//   the response is registered and appears in the cycle after the request
//   is accepted. one request per cycle is taken while the output register
//   is empty or being drained.
//   when rsp is stalled the pending response holds and req.ready drops
//   until it is taken; req.ready is high whenever the output register is
//   empty or being drained.
// reset:
//   synchronous rst empties both queues, clears the arrival count and the
//   pending response; entry storage is not cleared.
`timescale 1ns / 1ps

module two_class_fifo_oldest_first
  import tcfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
  input logic        clk,
  input logic        rst,
  tcfq_req_if.sink   req,
  tcfq_rsp_if.source rsp
);

  logic                  accept;
  action_t               act;
  logic [STAMP_BITS-1:0] arrival_count;
  logic [STAMP_BITS-1:0] arrival_count_next;

  logic [TAG_BITS+PORT_TAG_W-1:0] tag_ext_in;
  logic [TAG_BITS-1:0]            tag_in;

  q_ctl_t                dog_ctl;
  q_ctl_t                cat_ctl;
  q_sts_t                dog_sts;
  q_sts_t                cat_sts;
  logic [TAG_BITS-1:0]   dog_tag;
  logic [TAG_BITS-1:0]   cat_tag;
  logic [STAMP_BITS-1:0] dog_stamp;
  logic [STAMP_BITS-1:0] cat_stamp;
  logic [STAMP_BITS-1:0] age_diff;
  logic                  dog_older;

  logic                           take_dog;
  logic [TAG_BITS-1:0]            pop_tag;
  logic [TAG_BITS+PORT_TAG_W-1:0] tag_ext_out;

  status_t         res_status;
  logic [15:0]     res_tag;
  logic            res_dog;

  logic            out_valid;
  status_t         out_status;
  logic [15:0]     out_tag;
  logic            out_dog;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign act       = action_t'(req.action);

  assign tag_ext_in = {{TAG_BITS{1'b0}}, req.item_tag};
  assign tag_in     = tag_ext_in[TAG_BITS-1:0];

  assign age_diff  = cat_stamp - dog_stamp;
  assign dog_older = (age_diff != '0) && !age_diff[STAMP_BITS-1];

  always_comb begin
    dog_ctl            = '0;
    cat_ctl            = '0;
    take_dog           = 1'b0;
    res_status         = ST_EMPTY;
    arrival_count_next = arrival_count;
    case (act)
      ACT_ENQUEUE: begin
        if (req.is_dog ? dog_sts.full : cat_sts.full) begin
          res_status = ST_FULL;
        end else begin
          res_status         = ST_ENQUEUED;
          dog_ctl.push       = accept && req.is_dog;
          cat_ctl.push       = accept && !req.is_dog;
          arrival_count_next = arrival_count + STAMP_BITS'(1);
        end
      end
      ACT_DEQ_ANY: begin
        if (!(dog_sts.empty && cat_sts.empty)) begin
          res_status  = ST_DEQUEUED;
          take_dog    = cat_sts.empty || (!dog_sts.empty && dog_older);
          dog_ctl.pop = accept && take_dog;
          cat_ctl.pop = accept && !take_dog;
        end
      end
      ACT_DEQ_DOG: begin
        if (!dog_sts.empty) begin
          res_status  = ST_DEQUEUED;
          take_dog    = 1'b1;
          dog_ctl.pop = accept;
        end
      end
      ACT_DEQ_CAT: begin
        if (!cat_sts.empty) begin
          res_status  = ST_DEQUEUED;
          cat_ctl.pop = accept;
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  assign pop_tag     = take_dog ? dog_tag : cat_tag;
  assign tag_ext_out = {{PORT_TAG_W{1'b0}}, pop_tag};
  assign res_tag     = (res_status == ST_DEQUEUED) ? tag_ext_out[PORT_TAG_W-1:0] : '0;
  assign res_dog     = (res_status == ST_DEQUEUED) && take_dog;

  tcfq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dog (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dog_ctl),
    .in_tag     (tag_in),
    .in_stamp   (arrival_count),
    .head_tag   (dog_tag),
    .head_stamp (dog_stamp),
    .sts        (dog_sts)
  );

  tcfq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_cat (
    .clk        (clk),
    .rst        (rst),
    .ctl        (cat_ctl),
    .in_tag     (tag_in),
    .in_stamp   (arrival_count),
    .head_tag   (cat_tag),
    .head_stamp (cat_stamp),
    .sts        (cat_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        arrival_count <= arrival_count_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res_status;
      out_tag    <= res_tag;
      out_dog    <= res_dog;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.out_tag    = out_tag;
  assign rsp.out_is_dog = out_dog;

endmodule

// ===== tb/tb_two_class_fifo_oldest_first.sv =====
// self-checking testbench for two_class_fifo_oldest_first
// drives requests; expects each response from a model of both queues or from the directed table
// depends on tcfq_pkg, tcfq_ifs and the rtl of the block
`timescale 1ns / 1ps

module tb_two_class_fifo_oldest_first;
  import tcfq_pkg::*;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int STAMP_W     = DEF_STAMP_BITS;
  localparam int PARK_RUN    = 32;
  localparam int RAND_ITEMS  = 1500;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    action_t     act;
    logic        dog;
    logic [15:0] tag;
  } op_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] tag;
    logic        dog;
  } resp_t;

  typedef struct {
    logic [15:0]        tag;
    logic [STAMP_W-1:0] stamp;
  } pet_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] reps;
    logic       typed;
    resp_t      want;
  } row_t;

  localparam int N_ROWS = 14;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{'{ACT_DEQ_ANY, 1'b0, 16'h0000}, 5'd1,  1'b1, '{ST_EMPTY,    16'h0000, 1'b0}},
    '{'{ACT_DEQ_DOG, 1'b1, 16'hffff}, 5'd1,  1'b1, '{ST_EMPTY,    16'h0000, 1'b0}},
    '{'{ACT_DEQ_CAT, 1'b1, 16'hffff}, 5'd1,  1'b1, '{ST_EMPTY,    16'h0000, 1'b0}},
    '{'{ACT_ENQUEUE, 1'b0, 16'h0000}, 5'd1,  1'b1, '{ST_ENQUEUED, 16'h0000, 1'b0}},
    '{'{ACT_ENQUEUE, 1'b1, 16'hffff}, 5'd1,  1'b1, '{ST_ENQUEUED, 16'h0000, 1'b0}},
    '{'{ACT_DEQ_ANY, 1'b1, 16'h0000}, 5'd1,  1'b1, '{ST_DEQUEUED, 16'h0000, 1'b0}},
    '{'{ACT_DEQ_ANY, 1'b0, 16'hffff}, 5'd1,  1'b1, '{ST_DEQUEUED, 16'hffff, 1'b1}},
    '{'{ACT_ENQUEUE, 1'b1, 16'h8000}, 5'd16, 1'b1, '{ST_ENQUEUED, 16'h0000, 1'b0}},
    '{'{ACT_ENQUEUE, 1'b1, 16'h1234}, 5'd1,  1'b1, '{ST_FULL,     16'h0000, 1'b0}},
    '{'{ACT_ENQUEUE, 1'b0, 16'h7fff}, 5'd1,  1'b1, '{ST_ENQUEUED, 16'h0000, 1'b0}},
    '{'{ACT_DEQ_ANY, 1'b0, 16'h5555}, 5'd1,  1'b1, '{ST_DEQUEUED, 16'h8000, 1'b1}},
    '{'{ACT_DEQ_CAT, 1'b1, 16'hffff}, 5'd1,  1'b1, '{ST_DEQUEUED, 16'h7fff, 1'b0}},
    '{'{ACT_DEQ_ANY, 1'b1, 16'haaaa}, 5'd1,  1'b0, '{ST_EMPTY,    16'h0000, 1'b0}},
    '{'{ACT_DEQ_DOG, 1'b0, 16'h0001}, 5'd1,  1'b0, '{ST_EMPTY,    16'h0000, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcfq_req_if req_ch ();
  tcfq_rsp_if rsp_ch ();

  two_class_fifo_oldest_first u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the two queues and the arrival counter
  pet_t               dog_line [$];
  pet_t               cat_line [$];
  logic [STAMP_W-1:0] next_stamp;
  resp_t              owed_responses [$];

  bit    req_taken;
  bit    cur_typed;
  resp_t cur_want;
  int    send_idle;
  int    recv_stall;
  int    hold_left;
  int    mismatches;
  int    cycles;

  function automatic op_t make_op(action_t act, logic dog, logic [15:0] tag);
    op_t op;
    op.act = act;
    op.dog = dog;
    op.tag = tag;
    return op;
  endfunction

  function automatic resp_t serve_request(op_t op);
    resp_t              r;
    pet_t               p;
    bit                 take_dog;
    bit                 take_cat;
    logic [STAMP_W-1:0] gap;
    r = '{ST_EMPTY, 16'h0000, 1'b0};
    take_dog = 1'b0;
    take_cat = 1'b0;
    gap = '0;
    case (op.act)
      ACT_ENQUEUE: begin
        if ((op.dog ? dog_line.size() : cat_line.size()) >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          p.tag = op.tag;
          p.stamp = next_stamp;
          if (op.dog) dog_line.push_back(p);
          else cat_line.push_back(p);
          next_stamp = next_stamp + 1'b1;
          r.st = ST_ENQUEUED;
        end
      end
      ACT_DEQ_ANY: begin
        if (dog_line.size() != 0 && cat_line.size() != 0)
          gap = cat_line[0].stamp - dog_line[0].stamp;
        take_dog = dog_line.size() != 0 &&
                   (cat_line.size() == 0 || (gap != 0 && !gap[STAMP_W-1]));
        take_cat = cat_line.size() != 0 && !take_dog;
      end
      ACT_DEQ_DOG: take_dog = dog_line.size() != 0;
      ACT_DEQ_CAT: take_cat = cat_line.size() != 0;
    endcase
    if (take_dog) begin
      p = dog_line.pop_front();
      r = '{ST_DEQUEUED, p.tag, 1'b1};
    end else if (take_cat) begin
      p = cat_line.pop_front();
      r = '{ST_DEQUEUED, p.tag, 1'b0};
    end
    return r;
  endfunction

  // response check first: a response never belongs to a request taken at the same edge
  always @(posedge clk) begin
    resp_t want;
    resp_t got;
    op_t   op;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_responses.size() == 0) begin
        $error("unexpected transaction: status %0d out_tag %h out_is_dog %b",
               rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_is_dog);
        mismatches++;
      end else begin
        want = owed_responses.pop_front();
        if (rsp_ch.status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.out_tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, rsp_ch.out_tag);
          mismatches++;
        end
        if (rsp_ch.out_is_dog !== want.dog) begin
          $error("out_is_dog: expected %b, got %b", want.dog, rsp_ch.out_is_dog);
          mismatches++;
        end
      end
    end
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      op = make_op(action_t'(req_ch.action), req_ch.is_dog, req_ch.item_tag);
      got = serve_request(op);
      owed_responses.push_back(cur_typed ? cur_want : got);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= $urandom_range(0, 99) >= recv_stall;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL two_class_fifo_oldest_first");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(op_t op, bit typed = 1'b0, resp_t want = '0);
    while ($urandom_range(0, 99) < send_idle) begin
      req_ch.valid <= 1'b0;
      req_ch.action <= 2'($urandom);
      req_ch.is_dog <= 1'($urandom);
      req_ch.item_tag <= 16'($urandom);
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= op.act;
    req_ch.is_dog <= op.dog;
    req_ch.item_tag <= op.tag;
    cur_typed = typed;
    cur_want = want;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_responses.size() != 0) @(negedge clk);
  endtask

  function automatic op_t random_op(int enq_pct);
    op_t op;
    op.dog = 1'($urandom);
    op.tag = 16'($urandom);
    if ($urandom_range(0, 99) < enq_pct) op.act = ACT_ENQUEUE;
    else op.act = action_t'($urandom_range(1, 3));
    return op;
  endfunction

  initial begin
    op_t op;
    int  n;
    int  enq_pct;
    int  idle_plan [4][2];
    idle_plan = '{'{0, 0}, '{49, 0}, '{0, 49}, '{33, 33}};
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ENQUEUE;
    req_ch.is_dog = 1'b0;
    req_ch.item_tag = 16'h0000;
    rsp_ch.ready = 1'b0;
    next_stamp = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_left = 0;
    mismatches = 0;
    cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        op = DIRECTED[r].op;
        op.tag = op.tag + 16'(k);
        offer(op, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // empty both queues, then park one dog behind a run of cats
    settle();
    n = dog_line.size();
    repeat (n) offer(make_op(ACT_DEQ_DOG, 1'($urandom), 16'($urandom)));
    n = cat_line.size();
    repeat (n) offer(make_op(ACT_DEQ_CAT, 1'($urandom), 16'($urandom)));
    offer(make_op(ACT_ENQUEUE, 1'b1, 16'($urandom)));
    for (int k = 1; k <= PARK_RUN; k++) begin
      offer(make_op(ACT_ENQUEUE, 1'b0, 16'($urandom)));
      if (k % 8 == 0)
        offer(make_op(ACT_DEQ_ANY, 1'($urandom), 16'($urandom)));
      else
        offer(make_op(ACT_DEQ_CAT, 1'($urandom), 16'($urandom)));
    end
    offer(make_op(ACT_DEQ_ANY, 1'($urandom), 16'($urandom)));
    settle();

    enq_pct = 50;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_plan[ph][0];
      recv_stall = idle_plan[ph][1];
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (i % 32 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
          endcase
        end
        if (ph == 0 && i == 100) begin
          req_ch.valid <= 1'b0;
          @(posedge clk);
          hold_left = 150;
          @(negedge clk);
        end
        offer(random_op(enq_pct));
      end
      settle();
    end

    recv_stall = 0;
    repeat (8) @(negedge clk);
    if (mismatches == 0 && owed_responses.size() == 0) begin
      $display("PASS two_class_fifo_oldest_first");
    end else begin
      $display("FAIL two_class_fifo_oldest_first");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcfq_pkg.sv
sv/tcfq_ifs.sv
sv/tcfq_cell.sv
sv/tcfq_chain.sv
sv/two_class_fifo_oldest_first.sv
tb/tb_two_class_fifo_oldest_first.sv
